[rtl/core/fsa_pkg.sv]
// Package for the fixed slot allocator core: transaction types, sizes,
// register indexes and shared-unit operation codes.
// No dependencies; every other file of the core imports it.
`default_nettype none

package fsa_pkg;

  // Built maximum of slots and the widths that follow from it.
  localparam int MAX_SLOTS = 64;
  localparam int IDX_W     = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int STEP_W    = $clog2(IDX_W + 1);

  // Field and register widths.
  localparam int ADDR_W    = 32;
  localparam int SIZE_W    = 13;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BASE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS      = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [ADDR_W-1:0] RST_BASE       = 32'd0;
  localparam logic [SIZE_W-1:0] RST_SLOT_BYTES = 13'd16;
  localparam logic [CNT_W-1:0]  RST_SLOTS      = 7'd64;

  // Command codes.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Operations of the shared add/subtract unit.
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  // Request transaction.
  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] address;
  } fsa_req_t;

  // Response transaction.
  typedef struct packed {
    logic              granted;
    logic [IDX_W-1:0]  slot_num;
    logic [ADDR_W-1:0] slot_address;
  } fsa_rsp_t;

  // Update of the use map from the sequencer.
  typedef struct packed {
    logic             set;
    logic             clr;
    logic [IDX_W-1:0] idx;
  } map_cmd_t;

endpackage

`default_nettype wire

[rtl/core/fsa_alu.sv]
// Shared 32-bit add/subtract unit of the slot allocator; its carry out
// doubles as the unsigned a >= b flag on a subtraction.
// Depends on fsa_pkg.
`default_nettype none

module fsa_alu (
  input  fsa_pkg::alu_op_t            op,
  input  logic [fsa_pkg::ADDR_W-1:0]  a,
  input  logic [fsa_pkg::ADDR_W-1:0]  b,
  output logic [fsa_pkg::ADDR_W-1:0]  result,
  output logic                        carry
);
  import fsa_pkg::*;

  logic [ADDR_W-1:0] b_eff;
  logic              cin;

  // A subtraction adds the inverted operand plus one.
  always_comb begin
    b_eff = (op == ALU_SUB) ? ~b : b;
    cin   = (op == ALU_SUB);
  end

  assign {carry, result} = {1'b0, a} + {1'b0, b_eff} + {{ADDR_W{1'b0}}, cin};

endmodule

`default_nettype wire

[rtl/core/fsa_slot_map.sv]
// Use map of the slot allocator: one taken bit per slot, cleared by reset,
// with one update port and one read port.
// Depends on fsa_pkg.
`default_nettype none

module fsa_slot_map (
  input  logic                       clk,
  input  logic                       rst,
  input  fsa_pkg::map_cmd_t          cmd,
  input  logic [fsa_pkg::IDX_W-1:0]  rd_idx,
  output logic                       rd_taken
);
  import fsa_pkg::*;

  logic [MAX_SLOTS-1:0] taken;

  // Mark a slot taken on a grant, free on an accepted release.
  always_ff @(posedge clk) begin
    if (rst) begin
      taken <= '0;
    end else if (cmd.set) begin
      taken[cmd.idx] <= 1'b1;
    end else if (cmd.clr) begin
      taken[cmd.idx] <= 1'b0;
    end
  end

  assign rd_taken = taken[rd_idx];

endmodule

`default_nettype wire

[rtl/core/fixed_slot_allocator_core.sv]
// Fixed slot allocator: grants the lowest free slot of a pool, frees slots by address.
// Allocate: grant, shift-add multiply for the address, upward search for the next free
// slot. Free: subtract, multiply, compare, divide if in range; full/empty skip the rest.
// One transaction at a time: the next request is taken the cycle after the response is
// loaded into the output register, where it waits while stalled. One shared adder.
// Synchronous active-high reset frees all slots and restores register defaults.
`default_nettype none

module fixed_slot_allocator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fsa_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  fsa_pkg::fsa_req_t             req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output fsa_pkg::fsa_rsp_t             rsp
);
  import fsa_pkg::*;

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ALLOC = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_FSUB  = 4'd4;
  localparam logic [3:0] S_FCMP  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_FFIN  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]        state;

  // Configuration registers.
  logic [ADDR_W-1:0] base_address;
  logic [SIZE_W-1:0] slot_bytes;
  logic [CNT_W-1:0]  slots_in_use;
  logic [CNT_W-1:0]  pool_n;

  // Working registers.
  logic              cmd;
  logic [ADDR_W-1:0] address;
  logic [ADDR_W-1:0] acc;
  logic [ADDR_W-1:0] mcand;
  logic [ADDR_W-1:0] off;
  logic [IDX_W-1:0]  mplier;
  logic [IDX_W-1:0]  idx;
  logic [STEP_W-1:0] cnt;
  logic [CNT_W-1:0]  scan_i;
  logic [CNT_W-1:0]  lowest_free;
  fsa_rsp_t          res_hold;

  // Shared unit and map connections.
  alu_op_t           alu_op;
  logic [ADDR_W-1:0] alu_a;
  logic [ADDR_W-1:0] alu_b;
  logic [ADDR_W-1:0] alu_result;
  logic              alu_carry;
  logic [ADDR_W-1:0] acc_step;
  map_cmd_t          map_cmd;
  logic              map_taken;
  logic              last_step;
  logic              rsp_free;

  // Number of managed slots, clamped to the built maximum.
  assign pool_n = (slots_in_use > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : slots_in_use;

  assign req_stall = (state != S_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign last_step = (cnt == STEP_W'(IDX_W - 1));

  // Operand selection for the shared adder.
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = acc;
    alu_b  = mcand;
    unique case (state)
      S_FSUB: begin
        alu_op = ALU_SUB;
        alu_a  = address;
        alu_b  = base_address;
      end
      S_FCMP: begin
        alu_op = ALU_SUB;
        alu_a  = acc;
        alu_b  = off;
      end
      S_DIV: begin
        alu_op = ALU_SUB;
        alu_a  = off;
        alu_b  = mcand;
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  fsa_alu u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .result (alu_result),
    .carry  (alu_carry)
  );

  // Shift-add multiply: add the shifted multiplicand when the low bit is set.
  assign acc_step = mplier[0] ? alu_result : acc;

  // Map updates: set on a grant, clear when a free completes.
  always_comb begin
    map_cmd.set = (state == S_ALLOC) && (lowest_free < pool_n);
    map_cmd.clr = (state == S_FFIN);
    map_cmd.idx = (state == S_FFIN) ? idx : lowest_free[IDX_W-1:0];
  end

  fsa_slot_map u_map (
    .clk      (clk),
    .rst      (rst),
    .cmd      (map_cmd),
    .rd_idx   (scan_i[IDX_W-1:0]),
    .rd_taken (map_taken)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= RST_BASE;
      slot_bytes   <= RST_SLOT_BYTES;
      slots_in_use <= RST_SLOTS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE:       base_address <= cfg_data[ADDR_W-1:0];
        REG_SLOT_BYTES: slot_bytes   <= cfg_data[SIZE_W-1:0];
        REG_SLOTS:      slots_in_use <= cfg_data[CNT_W-1:0];
        default:        ;
      endcase
    end
  end

  // Sequencer with its control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      lowest_free <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      // The output register fills from the completion state and empties on acceptance.
      if (state == S_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= (req.cmd == CMD_FREE) ? S_FSUB : S_ALLOC;
          end
        end
        S_ALLOC: begin
          state <= (lowest_free < pool_n) ? S_MUL : S_DONE;
        end
        S_MUL: begin
          if (last_step) begin
            state <= (cmd == CMD_FREE) ? S_FCMP : S_SCAN;
          end
        end
        S_SCAN: begin
          // Stop at the first free slot or at the end of the pool.
          if (scan_i >= pool_n) begin
            lowest_free <= pool_n;
            state       <= S_DONE;
          end else if (!map_taken) begin
            lowest_free <= scan_i;
            state       <= S_DONE;
          end
        end
        S_FSUB: begin
          state <= (pool_n == '0) ? S_DONE : S_MUL;
        end
        S_FCMP: begin
          if (!alu_carry) begin
            state <= S_DONE;
          end else if (slot_bytes == '0) begin
            state <= S_FFIN;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (last_step) begin
            state <= S_FFIN;
          end
        end
        S_FFIN: begin
          if ({1'b0, idx} < lowest_free) begin
            lowest_free <= {1'b0, idx};
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers; these need no reset.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        cmd     <= req.cmd;
        address <= req.address;
      end
      S_ALLOC: begin
        // Grant the lowest free slot, then form its address as base + idx * size.
        idx    <= lowest_free[IDX_W-1:0];
        acc    <= base_address;
        mcand  <= ADDR_W'(slot_bytes);
        mplier <= lowest_free[IDX_W-1:0];
        cnt    <= '0;
        if (lowest_free < pool_n) begin
          res_hold.granted  <= 1'b1;
          res_hold.slot_num <= lowest_free[IDX_W-1:0];
        end else begin
          res_hold <= '0;
        end
      end
      S_MUL: begin
        acc    <= acc_step;
        mcand  <= {mcand[ADDR_W-2:0], 1'b0};
        mplier <= mplier >> 1;
        cnt    <= cnt + STEP_W'(1);
        if (last_step) begin
          // Only an allocation reports an address; a free keeps it at zero.
          if (cmd == CMD_ALLOC) begin
            res_hold.slot_address <= acc_step;
          end
          scan_i <= {1'b0, idx} + CNT_W'(1);
        end
      end
      S_FSUB: begin
        // Offset into the pool, then the top offset (n - 1) * size.
        off      <= alu_result;
        acc      <= '0;
        mcand    <= ADDR_W'(slot_bytes);
        mplier   <= IDX_W'(pool_n - CNT_W'(1));
        cnt      <= '0;
        res_hold <= '0;
      end
      S_SCAN: begin
        scan_i <= scan_i + CNT_W'(1);
      end
      S_FCMP: begin
        // Restoring division; the quotient stays below the pool size.
        mcand <= ADDR_W'(slot_bytes) << (IDX_W - 1);
        idx   <= '0;
        cnt   <= '0;
      end
      S_DIV: begin
        if (alu_carry) begin
          off <= alu_result;
        end
        idx   <= {idx[IDX_W-2:0], alu_carry};
        mcand <= mcand >> 1;
        cnt   <= cnt + STEP_W'(1);
      end
      S_FFIN: begin
        res_hold.granted  <= 1'b1;
        res_hold.slot_num <= idx;
      end
      S_DONE: begin
        if (rsp_free) begin
          rsp <= res_hold;
        end
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  // A refused transaction carries neither index nor address.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.granted |-> rsp.slot_num == '0 && rsp.slot_address == '0)
    else $error("refused response carries a nonzero index or address");

  // The first-free index never passes the built maximum.
  assert property (@(posedge clk) disable iff (rst)
    lowest_free <= CNT_W'(MAX_SLOTS))
    else $error("first-free index beyond the pool maximum");

  // The block is busy in the cycle after a request is taken.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken without entering the busy phase");

  // A response is raised only out of the completion state, when the output register is free.
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_DONE)
    else $error("response raised outside the completion state");
`endif

endmodule

`default_nettype wire
